// ----- src/csq_pkg.sv -----
// Shared types, constants and helper functions for the CSQ response parser.
`timescale 1ns / 1ps
`default_nettype none

package csq_pkg;

    // Depth of the word queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_S     = 8'h53;

    // rssi code 0 maps to -113 dBm
    localparam logic signed [7:0] RSSI_BASE = -8'sd113;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_N1_PRE,
        PH_N1_DIG,
        PH_N2_PRE,
        PH_N2_DIG,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_PREFIX  = 3'd1,
        ST_BAD_FIRST  = 3'd2,
        ST_NO_COMMA   = 3'd3,
        ST_BAD_SECOND = 3'd4
    } status_t;

    // One classified word from the front to the back
    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] digit;
        logic       is_digit;
        logic       is_space;
        logic       is_plus;
        logic       is_minus;
        logic       is_comma;
        logic       is_zero;
        logic       capture_end;
        logic       complete;
        logic [6:0] length;
    } csq_word_t;

    // Parser state at the end of a capture
    typedef struct packed {
        phase_t            phase;
        logic [31:0]       acc;
        logic              neg;
        logic              ovf;
        logic signed [7:0] rssi;
        logic              rssi_written;
        status_t           status;
        logic [7:0]        ber;
        logic              complete;
        logic [6:0]        length;
    } csq_snap_t;

    // One finished result
    typedef struct packed {
        status_t           status;
        logic              complete;
        logic              rssi_written;
        logic signed [7:0] rssi_dbm;
        logic [7:0]        ber_tenths;
        logic [6:0]        captured_length;
    } csq_result_t;

    // Characters of the "+CSQ:" prefix
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = CH_PLUS;
            3'd1:    ch = CH_C;
            3'd2:    ch = CH_S;
            3'd3:    ch = CH_Q;
            3'd4:    ch = CH_COLON;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    // Final 32-bit value, negated modulo 2^32 for a leading minus
    function automatic logic [31:0] num_value(input logic [31:0] acc, input logic neg);
        return neg ? (32'd0 - acc) : acc;
    endfunction

    // dBm for rssi codes 0..31, zero otherwise
    function automatic logic signed [7:0] rssi_code(input logic [31:0] v);
        logic signed [7:0] r;
        r = 8'sd0;
        if (v < 32'd32) begin
            r = RSSI_BASE + $signed({2'b00, v[4:0], 1'b0});
        end
        return r;
    endfunction

    // ber in tenths of a percent for codes 0..7, zero otherwise
    function automatic logic [7:0] ber_code(input logic [31:0] v);
        logic [7:0] b;
        b = 8'd0;
        if (v < 32'd8) begin
            unique case (v[2:0])
                3'd0:    b = 8'd2;
                3'd1:    b = 8'd3;
                3'd2:    b = 8'd6;
                3'd3:    b = 8'd12;
                3'd4:    b = 8'd24;
                3'd5:    b = 8'd48;
                3'd6:    b = 8'd96;
                default: b = 8'd128;
            endcase
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- src/csq_front.sv -----
// Front: accepts bytes, tracks capture length and terminators, classifies each word.
`timescale 1ns / 1ps
`default_nettype none

module csq_front
    import csq_pkg::*;
#(
    parameter int CAPTURE_LIMIT = 128
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_end_of_response,
    output logic            push_o,
    output csq_word_t       word_o,
    input  wire logic       full_i
);

    localparam int CW = $clog2(CAPTURE_LIMIT);

    logic [7:0]      hist_reg [6];
    logic [CW-1:0]   count_reg;
    logic            complete_reg;

    logic [7:0]      win [7];
    logic [CW-1:0]   count_next;
    logic [CW+6:0]   count_ext;
    logic            ok_hit;
    logic            err_hit;
    logic            ok_block;
    logic            err_block;
    logic            is_crlf;
    logic            complete_next;
    logic            capture_end;
    logic            accept;

    assign s_ready = !full_i;
    assign accept  = s_valid && !full_i;
    assign push_o  = accept;

    // Window of the newest seven bytes, current byte first
    always_comb begin
        win[0] = s_data_byte;
        for (int i = 1; i < 7; i++) begin
            win[i] = hist_reg[i-1];
        end
    end

    // Look for OK / ERROR from the oldest start; a zero byte hides later matches
    always_comb begin
        ok_hit    = 1'b0;
        ok_block  = 1'b0;
        err_hit   = 1'b0;
        err_block = 1'b0;
        for (int p = 3; p >= 1; p--) begin
            if (!ok_block && win[p] == CH_O && win[p-1] == CH_K) begin
                ok_hit = 1'b1;
            end
            if (win[p] == CH_NUL) begin
                ok_block = 1'b1;
            end
        end
        for (int p = 6; p >= 4; p--) begin
            if (!err_block && win[p] == CH_E && win[p-1] == CH_R && win[p-2] == CH_R &&
                win[p-3] == CH_O && win[p-4] == CH_R) begin
                err_hit = 1'b1;
            end
            if (win[p] == CH_NUL) begin
                err_block = 1'b1;
            end
        end
    end

    // Capture end decision
    always_comb begin
        count_next    = count_reg + CW'(1);
        count_ext     = {7'd0, count_next};
        is_crlf       = (s_data_byte == CH_CR) || (s_data_byte == CH_LF);
        complete_next = complete_reg ||
                        (is_crlf && ((count_next >= CW'(4) && ok_hit) ||
                                     (count_next >= CW'(7) && err_hit)));
        capture_end   = complete_next || (count_next >= CW'(CAPTURE_LIMIT - 1)) ||
                        s_end_of_response;
    end

    // Classified word for the back
    always_comb begin
        word_o.data_byte   = s_data_byte;
        word_o.digit       = s_data_byte[3:0];
        word_o.is_digit    = (s_data_byte >= CH_ZERO) && (s_data_byte <= CH_NINE);
        word_o.is_space    = (s_data_byte == CH_SPACE) ||
                             ((s_data_byte >= CH_TAB) && (s_data_byte <= CH_CR));
        word_o.is_plus     = (s_data_byte == CH_PLUS);
        word_o.is_minus    = (s_data_byte == CH_MINUS);
        word_o.is_comma    = (s_data_byte == CH_COMMA);
        word_o.is_zero     = (s_data_byte == CH_NUL);
        word_o.capture_end = capture_end;
        word_o.complete    = complete_next;
        word_o.length      = count_ext[6:0];
    end

    // History, count and completion; all cleared when a capture ends
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            complete_reg <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                hist_reg[i] <= 8'd0;
            end
        end else if (accept) begin
            if (capture_end) begin
                count_reg    <= '0;
                complete_reg <= 1'b0;
                for (int i = 0; i < 6; i++) begin
                    hist_reg[i] <= 8'd0;
                end
            end else begin
                count_reg    <= count_next;
                complete_reg <= complete_next;
                for (int i = 0; i < 6; i++) begin
                    hist_reg[i] <= win[i];
                end
            end
        end
    end

`ifndef SYNTHESIS
    // A capture end must leave the front in its reset state
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && capture_end |=> count_reg == '0 && !complete_reg)
        else $error("front not cleared after capture end");
`endif

endmodule

`default_nettype wire

// ----- src/csq_fifo.sv -----
// Short word queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module csq_fifo
    import csq_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push_i,
    input  csq_word_t       push_word_i,
    output logic            full_o,
    input  wire logic       pop_i,
    output csq_word_t       pop_word_o,
    output logic            empty_o
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    csq_word_t       mem [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW:0]     count_reg;

    assign full_o     = (count_reg == (AW+1)'(QUEUE_DEPTH));
    assign empty_o    = (count_reg == '0);
    assign pop_word_o = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push_i) begin
            mem[wr_ptr_reg] <= push_word_i;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_i) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop_i) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (push_i && !pop_i) begin
                count_reg <= count_reg + (AW+1)'(1);
            end else if (pop_i && !push_i) begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_i |-> !full_o)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_i |-> !empty_o)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ----- src/csq_back.sv -----
// Back: prefix search and number parser, one queued word per cycle; an empty queue or a held snapshot stalls it.
`timescale 1ns / 1ps
`default_nettype none

module csq_back
    import csq_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       empty_i,
    input  csq_word_t       word_i,
    output logic            pop_o,
    output logic            snap_valid_o,
    output csq_snap_t       snap_o,
    input  wire logic       snap_ready_i
);

    phase_t            phase_reg, phase_next;
    logic [2:0]        pos_reg, pos_next;
    logic [31:0]       acc_reg, acc_next;
    logic              sign_reg, sign_next;
    logic              neg_reg, neg_next;
    logic              ovf_reg, ovf_next;
    logic signed [7:0] rssi_reg, rssi_next;
    logic              rssi_wr_reg, rssi_wr_next;
    status_t           status_reg, status_next;
    logic [7:0]        ber_reg, ber_next;
    logic              snap_valid_reg;
    csq_snap_t         snap_reg;

    logic [31:0]       value;
    logic [35:0]       prod;
    logic              pre_fail;
    logic              end_pop;

    assign pop_o        = !empty_i && (!word_i.capture_end || !snap_valid_reg || snap_ready_i);
    assign end_pop      = pop_o && word_i.capture_end;
    assign snap_valid_o = snap_valid_reg;
    assign snap_o       = snap_reg;

    // Next parser state for the word at the queue head
    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        acc_next     = acc_reg;
        sign_next    = sign_reg;
        neg_next     = neg_reg;
        ovf_next     = ovf_reg;
        rssi_next    = rssi_reg;
        rssi_wr_next = rssi_wr_reg;
        status_next  = status_reg;
        ber_next     = ber_reg;

        value    = num_value(acc_reg, neg_reg);
        prod     = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {32'd0, word_i.digit};
        pre_fail = !word_i.is_digit &&
                   !(word_i.is_space && !sign_reg) &&
                   !((word_i.is_plus || word_i.is_minus) && !sign_reg);

        unique case (phase_reg)
            PH_SEARCH: begin
                if (word_i.is_zero) begin
                    status_next = ST_NO_PREFIX;
                    phase_next  = PH_DONE;
                end else if (word_i.data_byte == prefix_char(pos_reg)) begin
                    pos_next = pos_reg + 3'd1;
                    if (pos_reg == 3'd4) begin
                        phase_next = PH_N1_PRE;
                        acc_next   = 32'd0;
                        sign_next  = 1'b0;
                        neg_next   = 1'b0;
                        ovf_next   = 1'b0;
                    end
                end else begin
                    pos_next = word_i.is_plus ? 3'd1 : 3'd0;
                end
            end
            PH_N1_PRE, PH_N2_PRE: begin
                if (word_i.is_digit) begin
                    acc_next   = {28'd0, word_i.digit};
                    phase_next = (phase_reg == PH_N1_PRE) ? PH_N1_DIG : PH_N2_DIG;
                end else if (pre_fail) begin
                    status_next = (phase_reg == PH_N1_PRE) ? ST_BAD_FIRST : ST_BAD_SECOND;
                    phase_next  = PH_DONE;
                end else if (word_i.is_plus || word_i.is_minus) begin
                    sign_next = 1'b1;
                    neg_next  = neg_reg || word_i.is_minus;
                end
            end
            PH_N1_DIG: begin
                if (word_i.is_digit) begin
                    if (!ovf_reg) begin
                        acc_next = prod[31:0];
                        ovf_next = |prod[35:32];
                    end
                end else if (ovf_reg) begin
                    status_next = ST_BAD_FIRST;
                    phase_next  = PH_DONE;
                end else begin
                    rssi_next    = rssi_code(value);
                    rssi_wr_next = 1'b1;
                    if (word_i.is_comma) begin
                        phase_next = PH_N2_PRE;
                        acc_next   = 32'd0;
                        sign_next  = 1'b0;
                        neg_next   = 1'b0;
                        ovf_next   = 1'b0;
                    end else begin
                        status_next = ST_NO_COMMA;
                        phase_next  = PH_DONE;
                    end
                end
            end
            PH_N2_DIG: begin
                if (word_i.is_digit) begin
                    if (!ovf_reg) begin
                        acc_next = prod[31:0];
                        ovf_next = |prod[35:32];
                    end
                end else begin
                    if (ovf_reg) begin
                        status_next = ST_BAD_SECOND;
                    end else begin
                        ber_next    = ber_code(value);
                        status_next = ST_OK;
                    end
                    phase_next = PH_DONE;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Phase register; back to searching after each capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SEARCH;
        end else if (pop_o) begin
            phase_reg <= word_i.capture_end ? PH_SEARCH : phase_next;
        end
    end

    // Number and prefix state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= 3'd0;
            acc_reg     <= 32'd0;
            sign_reg    <= 1'b0;
            neg_reg     <= 1'b0;
            ovf_reg     <= 1'b0;
            rssi_reg    <= 8'sd0;
            rssi_wr_reg <= 1'b0;
            status_reg  <= ST_OK;
            ber_reg     <= 8'd0;
        end else if (pop_o) begin
            if (word_i.capture_end) begin
                pos_reg     <= 3'd0;
                acc_reg     <= 32'd0;
                sign_reg    <= 1'b0;
                neg_reg     <= 1'b0;
                ovf_reg     <= 1'b0;
                rssi_reg    <= 8'sd0;
                rssi_wr_reg <= 1'b0;
                status_reg  <= ST_OK;
                ber_reg     <= 8'd0;
            end else begin
                pos_reg     <= pos_next;
                acc_reg     <= acc_next;
                sign_reg    <= sign_next;
                neg_reg     <= neg_next;
                ovf_reg     <= ovf_next;
                rssi_reg    <= rssi_next;
                rssi_wr_reg <= rssi_wr_next;
                status_reg  <= status_next;
                ber_reg     <= ber_next;
            end
        end
    end

    // Snapshot handed to the report stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (end_pop) begin
            snap_valid_reg <= 1'b1;
        end else if (snap_ready_i) begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (end_pop) begin
            snap_reg.phase        <= phase_next;
            snap_reg.acc          <= acc_next;
            snap_reg.neg          <= neg_next;
            snap_reg.ovf          <= ovf_next;
            snap_reg.rssi         <= rssi_next;
            snap_reg.rssi_written <= rssi_wr_next;
            snap_reg.status       <= status_next;
            snap_reg.ber          <= ber_next;
            snap_reg.complete     <= word_i.complete;
            snap_reg.length       <= word_i.length;
        end
    end

endmodule

`default_nettype wire

// ----- src/csq_report.sv -----
// Report stage: resolves the final status and holds the result word.
`timescale 1ns / 1ps
`default_nettype none

module csq_report
    import csq_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       snap_valid_i,
    input  csq_snap_t       snap_i,
    output logic            snap_ready_o,
    output logic            m_valid,
    input  wire logic       m_ready,
    output csq_result_t     result_o
);

    logic        m_valid_reg;
    csq_result_t result_reg;
    csq_result_t result_next;
    logic [31:0] value;

    assign snap_ready_o = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign result_o     = result_reg;

    // Capture that ended mid-number: the end of text acts as a non-digit
    always_comb begin
        value                       = num_value(snap_i.acc, snap_i.neg);
        result_next.complete        = snap_i.complete;
        result_next.captured_length = snap_i.length;
        result_next.rssi_written    = snap_i.rssi_written;
        result_next.rssi_dbm        = snap_i.rssi;
        result_next.ber_tenths      = 8'd0;
        result_next.status          = snap_i.status;

        unique case (snap_i.phase)
            PH_SEARCH: result_next.status = ST_NO_PREFIX;
            PH_N1_PRE: result_next.status = ST_BAD_FIRST;
            PH_N1_DIG: begin
                if (snap_i.ovf) begin
                    result_next.status = ST_BAD_FIRST;
                end else begin
                    result_next.status       = ST_NO_COMMA;
                    result_next.rssi_written = 1'b1;
                    result_next.rssi_dbm     = rssi_code(value);
                end
            end
            PH_N2_PRE: result_next.status = ST_BAD_SECOND;
            PH_N2_DIG: begin
                if (snap_i.ovf) begin
                    result_next.status = ST_BAD_SECOND;
                end else begin
                    result_next.status     = ST_OK;
                    result_next.ber_tenths = ber_code(value);
                end
            end
            PH_DONE: begin
                if (snap_i.status == ST_OK) begin
                    result_next.ber_tenths = snap_i.ber;
                end
            end
            default: begin
            end
        endcase

        if (!result_next.rssi_written) begin
            result_next.rssi_dbm = 8'sd0;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (snap_ready_o) begin
            m_valid_reg <= snap_valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_ready_o && snap_valid_i) begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    a_ok_has_rssi: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && result_reg.status == ST_OK |-> result_reg.rssi_written)
        else $error("ok status without rssi");

    a_ber_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && result_reg.status != ST_OK |-> result_reg.ber_tenths == 8'd0)
        else $error("ber reported on a failed parse");
`endif

endmodule

`default_nettype wire

// ----- src/at_csq_response_parser_top.sv -----
// Path: a capture-ending byte enters the queue, then the back's snapshot, then the result word.
// Throughput: one byte per cycle while the queue is not full; the back parses one queued word a cycle,
// and a 4-word queue lets front and back stall independently.
// The report stage holds one result; a stalled output backs up into the queue.
// Reset: aresetn is synchronous, active low; it clears capture, parser and valid state.
`timescale 1ns / 1ps
`default_nettype none

module at_csq_response_parser_top
    import csq_pkg::*;
#(
    parameter int CAPTURE_LIMIT = 128
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_data_byte,
    input  wire logic              s_end_of_response,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [2:0]             m_status,
    output logic                   m_complete,
    output logic                   m_rssi_written,
    output logic signed [7:0]      m_rssi_dbm,
    output logic [7:0]             m_ber_tenths,
    output logic [6:0]             m_captured_length
);

    logic        push;
    logic        full;
    logic        pop;
    logic        empty;
    csq_word_t   push_word;
    csq_word_t   head_word;
    logic        snap_valid;
    logic        snap_ready;
    csq_snap_t   snap;
    csq_result_t result;

    csq_front #(
        .CAPTURE_LIMIT (CAPTURE_LIMIT)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_end_of_response (s_end_of_response),
        .push_o            (push),
        .word_o            (push_word),
        .full_i            (full)
    );

    csq_fifo u_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_i      (push),
        .push_word_i (push_word),
        .full_o      (full),
        .pop_i       (pop),
        .pop_word_o  (head_word),
        .empty_o     (empty)
    );

    csq_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .empty_i      (empty),
        .word_i       (head_word),
        .pop_o        (pop),
        .snap_valid_o (snap_valid),
        .snap_o       (snap),
        .snap_ready_i (snap_ready)
    );

    csq_report u_report (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .snap_valid_i (snap_valid),
        .snap_i       (snap),
        .snap_ready_o (snap_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .result_o     (result)
    );

    assign m_status          = result.status;
    assign m_complete        = result.complete;
    assign m_rssi_written    = result.rssi_written;
    assign m_rssi_dbm        = result.rssi_dbm;
    assign m_ber_tenths      = result.ber_tenths;
    assign m_captured_length = result.captured_length;

endmodule

`default_nettype wire
